### rtl/core/flow_priority_classifier_core_macros.svh
// Assertion macros for the flow priority classifier.
// No dependencies; included by modules that assert.
`ifndef FLOW_PRIORITY_CLASSIFIER_CORE_MACROS_SVH
`define FLOW_PRIORITY_CLASSIFIER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FPC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPC_ASSERT(label, clk, rst_n, prop, msg)
`define FPC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### rtl/core/fpc_pkg.sv
// Shared types and constants for the flow priority classifier.
// No dependencies.
package fpc_pkg;
  localparam int FLOW_ENTRIES  = 128;
  localparam int HI_PORT_SLOTS = 8;
  localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
  localparam int QDEPTH = 2;

  localparam logic [1:0] PRI_HIGH    = 2'd0;
  localparam logic [1:0] PRI_DEFAULT = 2'd1;
  localparam logic [1:0] PRI_LOW     = 2'd2;
  localparam logic [7:0] PROTO_ICMP = 8'h01;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic CMD_CLASSIFY = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  localparam logic [2:0] REG_PORT_COUNT = 3'd0;
  localparam logic [2:0] REG_PORTS_LO   = 3'd1;
  localparam logic [2:0] REG_PORTS_HI   = 3'd2;
  localparam logic [2:0] REG_IDLE       = 3'd3;
  localparam logic [2:0] REG_BULK       = 3'd4;
  localparam logic [2:0] REG_RATE       = 3'd5;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_FIXED  = 2'd2
  } op_t;

  // word handed from front to back
  typedef struct packed {
    op_t         op;
    logic [1:0]  pri;
    logic [31:0] now_ms;
    logic [15:0] sport;
    logic [31:0] addr;
    logic [15:0] len;
  } job_t;
endpackage

### rtl/core/fpc_front.sv
// Front end: accepts words, decides protocol and port priority, queues jobs.
// Depends on fpc_pkg and the core macros header.
`include "flow_priority_classifier_core_macros.svh"
module fpc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [31:0]         in_now_ms,
  input  logic [7:0]          in_protocol,
  input  logic [15:0]         in_source_port,
  input  logic [15:0]         in_dest_port,
  input  logic [31:0]         in_source_address,
  input  logic [15:0]         in_data_length,
  input  logic [3:0]          port_count,
  input  logic [127:0]        ports,
  output logic                job_valid,
  input  logic                job_ready,
  output fpc_pkg::job_t       job
);
  fpc_pkg::job_t q_r [fpc_pkg::QDEPTH];
  logic q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;
  logic hi;
  fpc_pkg::job_t nj;
  logic push, pop;

  always_comb begin
    hi = 1'b0;
    for (int k = 0; k < fpc_pkg::HI_PORT_SLOTS; k++) begin
      if ((k < int'(port_count)) &&
          (in_source_port == ports[k*16 +: 16] || in_dest_port == ports[k*16 +: 16]))
        hi = 1'b1;
    end
    nj.now_ms = in_now_ms;
    nj.sport  = in_source_port;
    nj.addr   = in_source_address;
    nj.len    = in_data_length;
    nj.pri    = fpc_pkg::PRI_DEFAULT;
    if (in_cmd == fpc_pkg::CMD_TICK) begin
      nj.op = fpc_pkg::OP_TICK;
    end else if (in_protocol == fpc_pkg::PROTO_ICMP) begin
      nj.op = fpc_pkg::OP_FIXED; nj.pri = fpc_pkg::PRI_HIGH;
    end else if (in_protocol != fpc_pkg::PROTO_TCP && in_protocol != fpc_pkg::PROTO_UDP) begin
      nj.op = fpc_pkg::OP_FIXED;
    end else if (hi) begin
      nj.op = fpc_pkg::OP_FIXED; nj.pri = fpc_pkg::PRI_HIGH;
    end else begin
      nj.op = fpc_pkg::OP_LOOKUP;
    end
  end

  assign in_ready  = (q_cnt_r != 2'(fpc_pkg::QDEPTH));
  assign push      = in_valid && in_ready;
  assign job_valid = (q_cnt_r != 2'd0);
  assign pop       = job_valid && job_ready;
  assign job       = q_r[q_rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[q_wp_r] <= nj;
    if (!rst_n) begin
      q_wp_r <= 1'b0; q_rp_r <= 1'b0; q_cnt_r <= 2'd0;
    end else begin
      if (push) q_wp_r <= ~q_wp_r;
      if (pop)  q_rp_r <= ~q_rp_r;
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(pop);
    end
  end

  `FPC_ASSERT(a_q_bound, clk, rst_n, q_cnt_r <= 2'(fpc_pkg::QDEPTH), "queue overfilled")
  `FPC_ASSERT(a_no_pop_empty, clk, rst_n, (q_cnt_r == 2'd0) |-> !pop, "pop from empty queue")
  `FPC_ASSERT(a_push_cnt, clk, rst_n, (push && !pop) |=> q_cnt_r == $past(q_cnt_r) + 2'd1, "count slip")
endmodule

### rtl/core/fpc_back.sv
// Back end: walks the flow table (read, then check, per entry) for lookups and ticks.
// Takes a new job only when idle. Depends on fpc_pkg and the core macros header.
`include "flow_priority_classifier_core_macros.svh"
module fpc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_ready,
  input  fpc_pkg::job_t       job,
  input  logic [31:0]         idle_limit,
  input  logic [31:0]         bulk,
  input  logic [19:0]         rate,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_priority_res
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_RD = 7'b0000010, S_CHK = 7'b0000100,
    S_DIV  = 7'b0001000, S_MUL = 7'b0010000, S_CMP = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;
  localparam int DW = 16 + 32 + 32 + 32 + 32; // port addr start last bytes

  logic [DW-1:0] mem [fpc_pkg::FLOW_ENTRIES];
  logic [fpc_pkg::FLOW_ENTRIES-1:0] vld_r, vld_nxt;
  state_t st_r, st_nxt;
  fpc_pkg::job_t j_r, j_nxt;
  logic [fpc_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic [fpc_pkg::IDX_W-1:0] ridx_r, ridx_nxt;
  logic [DW-1:0] rd_r;
  logic free_f_r, free_f_nxt;
  logic [fpc_pkg::IDX_W-1:0] free_r, free_nxt;
  logic [31:0] el_r, el_nxt, secs_r, secs_nxt, bytes_r, bytes_nxt;
  logic [51:0] prod_r, prod_nxt;
  logic [1:0] pri_r, pri_nxt;
  logic we; logic [fpc_pkg::IDX_W-1:0] wa; logic [DW-1:0] wd;
  logic [15:0] e_port; logic [31:0] e_addr, e_start, e_last, e_bytes;
  logic [32:0] sum; logic [31:0] el;
  logic [60:0] recip;
  logic ridx_v;

  assign {e_port, e_addr, e_start, e_last, e_bytes} = rd_r;
  assign job_ready = (st_r == S_IDLE);
  assign out_priority_res = pri_r;
  assign ridx_v = vld_r[ridx_r];

  always_ff @(posedge clk) begin
    rd_r <= mem[idx_r[fpc_pkg::IDX_W-1:0]];
    if (we) mem[wa] <= wd;
  end

  always_comb begin
    st_nxt = st_r; j_nxt = j_r; idx_nxt = idx_r; ridx_nxt = ridx_r;
    vld_nxt = vld_r; free_f_nxt = free_f_r; free_nxt = free_r;
    el_nxt = el_r; secs_nxt = secs_r; bytes_nxt = bytes_r; prod_nxt = prod_r;
    pri_nxt = pri_r;
    we = 1'b0; wa = ridx_r; wd = rd_r;
    sum = {1'b0, e_bytes} + {17'd0, j_r.len};
    el = j_r.now_ms - e_start;
    // elapsed ms / 1000 as floor(el * ceil(2^38/1000) / 2^38), exact for 32 bits
    recip = {29'd0, el_r} * 61'd274877907;
    case (st_r)
      S_IDLE: begin
        if (job_valid) begin
          j_nxt = job; idx_nxt = '0; free_f_nxt = 1'b0;
          if (job.op == fpc_pkg::OP_FIXED) begin
            pri_nxt = job.pri; st_nxt = S_OUT;
          end else begin
            st_nxt = S_RD;
          end
        end
      end
      S_RD: begin // memory read of entry idx in flight
        ridx_nxt = idx_r[fpc_pkg::IDX_W-1:0];
        idx_nxt = idx_r + 1'b1;
        st_nxt = S_CHK;
      end
      S_CHK: begin
        st_nxt = S_RD;
        if (j_r.op == fpc_pkg::OP_TICK) begin
          if (ridx_v && (j_r.now_ms - e_last) > idle_limit) vld_nxt[ridx_r] = 1'b0;
        end else if (ridx_v && e_port == j_r.sport && e_addr == j_r.addr) begin
          bytes_nxt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          we = 1'b1; wd = {e_port, e_addr, e_start, j_r.now_ms, bytes_nxt};
          el_nxt = el; // rd_r moves on next cycle, keep elapsed time
          if (bytes_nxt < bulk) begin
            pri_nxt = fpc_pkg::PRI_DEFAULT; st_nxt = S_OUT;
          end else begin
            st_nxt = S_DIV;
          end
        end else if (!ridx_v && !free_f_r) begin
          free_f_nxt = 1'b1; free_nxt = ridx_r;
        end
        if (st_nxt == S_RD && idx_r == fpc_pkg::CNT_W'(fpc_pkg::FLOW_ENTRIES)) begin
          if (j_r.op == fpc_pkg::OP_TICK) begin
            st_nxt = S_IDLE;
          end else begin
            // miss: take first free entry
            if (free_f_nxt) begin
              we = 1'b1; wa = free_nxt; vld_nxt[free_nxt] = 1'b1;
              wd = {j_r.sport, j_r.addr, j_r.now_ms, j_r.now_ms, 16'd0, j_r.len};
            end
            pri_nxt = fpc_pkg::PRI_DEFAULT; st_nxt = S_OUT;
          end
        end
      end
      S_DIV: begin // whole seconds by reciprocal multiply
        secs_nxt = {9'd0, recip[60:38]};
        st_nxt = S_MUL;
      end
      S_MUL: begin
        if (secs_r == 32'd0) secs_nxt = 32'd1;
        st_nxt = S_CMP;
        prod_nxt = {32'd0, rate} * {20'd0, (secs_r == 32'd0) ? 32'd1 : secs_r};
      end
      S_CMP: begin
        pri_nxt = ({20'd0, bytes_r} > prod_r) ? fpc_pkg::PRI_LOW : fpc_pkg::PRI_DEFAULT;
        st_nxt = S_OUT;
      end
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign out_valid = (st_r == S_OUT);

  always_ff @(posedge clk) begin
    j_r <= j_nxt; ridx_r <= ridx_nxt; free_r <= free_nxt; el_r <= el_nxt;
    secs_r <= secs_nxt; bytes_r <= bytes_nxt; prod_r <= prod_nxt;
    pri_r <= pri_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE; vld_r <= '0; idx_r <= '0; free_f_r <= 1'b0;
    end else begin
      st_r <= st_nxt; vld_r <= vld_nxt; idx_r <= idx_nxt; free_f_r <= free_f_nxt;
    end
  end

  `FPC_ASSERT(a_onehot, clk, rst_n, $onehot(st_r), "state not one-hot")
  `FPC_ASSERT(a_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid && $stable(pri_r), "result dropped")
  `FPC_ASSERT(a_pri_ok, clk, rst_n, out_valid |-> pri_r != 2'd3, "bad priority")
endmodule

### rtl/core/flow_priority_classifier_core.sv
// Top level of the flow priority classifier: config registers, front, back.
// Depends on fpc_pkg, fpc_front, fpc_back.
//
//  channel | dir | handshake            | payload
//  in      | in  | in_valid/in_ready    | cmd now_ms protocol ports address length
//  out     | out | out_valid/out_ready  | priority_res
//  cfg     | in  | cfg_valid/cfg_ready  | cfg_index cfg_data
//
// ICMP, non TCP/UDP and high-port packets skip the table walk: the queued job goes
// straight to the output state. Lookups and ticks walk the flow entries, each with a
// read then a check; a lookup hit at entry k stops the walk there.
// A hit at or above the bulk threshold then divides by 1000, forms the rate product,
// and compares. Reset clears the valid bits at once, so there is no clearing pass.
// The front queue holds two words, so up to two are taken while the back walks.
module flow_priority_classifier_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_now_ms,
  input  logic [7:0]  in_protocol,
  input  logic [15:0] in_source_port,
  input  logic [15:0] in_dest_port,
  input  logic [31:0] in_source_address,
  input  logic [15:0] in_data_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_priority_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  logic [3:0]  port_count_r;
  logic [63:0] ports_lo_r, ports_hi_r;
  logic [31:0] idle_r, bulk_r;
  logic [19:0] rate_r;
  logic [3:0]  pc_eff;
  logic        jv, jr;
  fpc_pkg::job_t jb;

  assign cfg_ready = 1'b1;
  // counts over the slot count clamp to all slots
  assign pc_eff = (port_count_r > 4'(fpc_pkg::HI_PORT_SLOTS)) ?
                  4'(fpc_pkg::HI_PORT_SLOTS) : port_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_count_r <= 4'd2;
      ports_lo_r   <= 64'd3473430;
      ports_hi_r   <= 64'd0;
      idle_r       <= 32'd30000;
      bulk_r       <= 32'd2000000;
      rate_r       <= 20'd5120;
    end else if (cfg_valid) begin
      case (cfg_index)
        fpc_pkg::REG_PORT_COUNT: port_count_r <= cfg_data[3:0];
        fpc_pkg::REG_PORTS_LO:   ports_lo_r   <= cfg_data;
        fpc_pkg::REG_PORTS_HI:   ports_hi_r   <= cfg_data;
        fpc_pkg::REG_IDLE:       idle_r       <= cfg_data[31:0];
        fpc_pkg::REG_BULK:       bulk_r       <= cfg_data[31:0];
        fpc_pkg::REG_RATE:       rate_r       <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  fpc_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_now_ms, .in_protocol,
    .in_source_port, .in_dest_port, .in_source_address, .in_data_length,
    .port_count(pc_eff), .ports({ports_hi_r, ports_lo_r}),
    .job_valid(jv), .job_ready(jr), .job(jb)
  );

  fpc_back u_back (
    .clk, .rst_n, .job_valid(jv), .job_ready(jr), .job(jb),
    .idle_limit(idle_r), .bulk(bulk_r), .rate(rate_r),
    .out_valid, .out_ready, .out_priority_res
  );
endmodule

### tb/tb_flow_priority_classifier_core.sv
// Self-checking testbench for flow_priority_classifier_core: random traffic
// against an in-bench priority predictor. Depends on fpc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_flow_priority_classifier_core;

  typedef struct {
    logic        cmd;
    logic [31:0] now_ms;
    logic [7:0]  protocol;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] addr;
    logic [15:0] len;
  } pkt_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [31:0] in_now_ms;
  logic [7:0]  in_protocol;
  logic [15:0] in_source_port;
  logic [15:0] in_dest_port;
  logic [31:0] in_source_address;
  logic [15:0] in_data_length;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_priority_res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  flow_priority_classifier_core uut (.*);

  // 2 ns clock
  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // ---------------------------------------------------------------------
  // Predictor state: config shadow and flow table copy
  // ---------------------------------------------------------------------
  logic [3:0]  port_cnt_q;
  logic [63:0] ports_lo_q;
  logic [63:0] ports_hi_q;
  logic [31:0] idle_ms_q;
  logic [31:0] bulk_q;
  logic [19:0] rate_q;

  logic        flow_live    [fpc_pkg::FLOW_ENTRIES];
  logic [15:0] flow_sport   [fpc_pkg::FLOW_ENTRIES];
  logic [31:0] flow_addr    [fpc_pkg::FLOW_ENTRIES];
  logic [31:0] flow_first_ms[fpc_pkg::FLOW_ENTRIES];
  logic [31:0] flow_seen_ms [fpc_pkg::FLOW_ENTRIES];
  logic [31:0] flow_count   [fpc_pkg::FLOW_ENTRIES];

  pkt_t       pkt_pending[$];
  logic [1:0] prio_expected[$];
  int         pkts_queued;
  int         pkts_taken;
  int         mismatches;
  logic       in_taken;
  logic       cfg_taken;
  logic       idle_on;

  // idle sweep: free entries idle strictly longer than the limit
  function automatic void age_flows(logic [31:0] now);
    for (int k = 0; k < fpc_pkg::FLOW_ENTRIES; k++)
      if (flow_live[k] && (now - flow_seen_ms[k]) > idle_ms_q) flow_live[k] = 1'b0;
  endfunction

  function automatic logic [1:0] classify_pkt(pkt_t p);
    int          slots;
    logic [15:0] hp;
    logic [32:0] sum;
    logic [31:0] secs;
    longint unsigned budget;
    if (p.protocol == fpc_pkg::PROTO_ICMP) return fpc_pkg::PRI_HIGH;
    if (p.protocol != fpc_pkg::PROTO_TCP && p.protocol != fpc_pkg::PROTO_UDP)
      return fpc_pkg::PRI_DEFAULT;
    slots = (port_cnt_q > fpc_pkg::HI_PORT_SLOTS) ? fpc_pkg::HI_PORT_SLOTS : port_cnt_q;
    for (int k = 0; k < slots; k++) begin
      hp = (k < 4) ? ports_lo_q[(k%4)*16 +: 16] : ports_hi_q[(k%4)*16 +: 16];
      if (p.sport == hp || p.dport == hp) return fpc_pkg::PRI_HIGH;
    end
    for (int k = 0; k < fpc_pkg::FLOW_ENTRIES; k++) begin
      if (flow_live[k] && flow_sport[k] == p.sport && flow_addr[k] == p.addr) begin
        flow_seen_ms[k] = p.now_ms;
        sum = {1'b0, flow_count[k]} + {17'd0, p.len};
        flow_count[k] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (flow_count[k] < bulk_q) return fpc_pkg::PRI_DEFAULT;
        secs = (p.now_ms - flow_first_ms[k]) / 1000;
        if (secs == 0) secs = 1;
        budget = longint'(rate_q) * longint'(secs);
        return (longint'(flow_count[k]) > budget) ? fpc_pkg::PRI_LOW : fpc_pkg::PRI_DEFAULT;
      end
    end
    // miss: take first free slot; full table stores nothing
    for (int k = 0; k < fpc_pkg::FLOW_ENTRIES; k++) begin
      if (!flow_live[k]) begin
        flow_live[k]     = 1'b1;
        flow_sport[k]    = p.sport;
        flow_addr[k]     = p.addr;
        flow_first_ms[k] = p.now_ms;
        flow_seen_ms[k]  = p.now_ms;
        flow_count[k]    = {16'd0, p.len};
        break;
      end
    end
    return fpc_pkg::PRI_DEFAULT;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: input word at falling edge, valid held until taken
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    pkt_t p;
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pkt_pending.size() > 0 && !(idle_on && $urandom_range(99) < 33)) begin
          p = pkt_pending.pop_front();
          in_cmd            <= p.cmd;
          in_now_ms         <= p.now_ms;
          in_protocol       <= p.protocol;
          in_source_port    <= p.sport;
          in_dest_port      <= p.dport;
          in_source_address <= p.addr;
          in_data_length    <= p.len;
          in_valid          <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !(idle_on && $urandom_range(99) < 33);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predict on accept, check results at rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    pkt_t       p;
    logic [1:0] want;
    in_taken  <= in_valid && in_ready;
    cfg_taken <= cfg_valid && cfg_ready;
    if (rst_n && in_valid && in_ready) begin
      p.cmd = in_cmd;  p.now_ms = in_now_ms;  p.protocol = in_protocol;
      p.sport = in_source_port;  p.dport = in_dest_port;
      p.addr = in_source_address;  p.len = in_data_length;
      pkts_taken++;
      if (p.cmd == fpc_pkg::CMD_TICK) age_flows(p.now_ms);
      else prio_expected.push_back(classify_pkt(p));
    end
    if (rst_n && out_valid && out_ready) begin
      if (prio_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected priority word %0d", out_priority_res);
      end else begin
        want = prio_expected.pop_front();
        if (want !== out_priority_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: priority expected %0d got %0d", want, out_priority_res);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  logic [31:0] clock_ms;
  logic [31:0] pool_addr[16];
  logic [15:0] pool_port[16];

  task automatic send(logic cmd, logic [31:0] now, logic [7:0] proto, logic [15:0] sp,
                      logic [15:0] dp, logic [31:0] addr, logic [15:0] len);
    pkt_t p;
    p.cmd = cmd;  p.now_ms = now;  p.protocol = proto;  p.sport = sp;
    p.dport = dp;  p.addr = addr;  p.len = len;
    pkt_pending.push_back(p);
    pkts_queued++;
  endtask

  // block idle: no word in flight, no result owed, then room for a tick walk
  task automatic settle();
    while (pkts_taken != pkts_queued || prio_expected.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
    case (idx)
      fpc_pkg::REG_PORT_COUNT: port_cnt_q = val[3:0];
      fpc_pkg::REG_PORTS_LO:   ports_lo_q = val;
      fpc_pkg::REG_PORTS_HI:   ports_hi_q = val;
      fpc_pkg::REG_IDLE:       idle_ms_q  = val[31:0];
      fpc_pkg::REG_BULK:       bulk_q     = val[31:0];
      fpc_pkg::REG_RATE:       rate_q     = val[19:0];
      default: ;
    endcase
  endtask

  task automatic new_pool();
    for (int k = 0; k < 16; k++) begin
      pool_addr[k] = $urandom;
      pool_port[k] = 16'($urandom);
    end
  endtask

  // mostly repeat traffic on a small set of flows so hits and bulk states show up
  task automatic random_traffic(int n);
    int          sel;
    int          r;
    logic [7:0]  proto;
    logic [15:0] dp;
    logic [15:0] len;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      clock_ms += (r < 5) ? $urandom : $urandom_range(0, 1500);
      if ($urandom_range(99) < 8) begin
        send(fpc_pkg::CMD_TICK, clock_ms, 8'($urandom), 16'($urandom), 16'($urandom),
             $urandom, 16'($urandom));
        continue;
      end
      r = $urandom_range(99);
      proto = (r < 45) ? fpc_pkg::PROTO_TCP : (r < 85) ? fpc_pkg::PROTO_UDP :
              (r < 92) ? fpc_pkg::PROTO_ICMP : 8'($urandom);
      r = $urandom_range(99);
      dp = (r < 10) ? ports_lo_q[$urandom_range(3)*16 +: 16] :
           (r < 20) ? ports_hi_q[$urandom_range(3)*16 +: 16] : 16'($urandom);
      r = $urandom_range(99);
      len = (r < 5) ? 16'hFFFF : (r < 10) ? 16'h0 : 16'($urandom);
      sel = $urandom_range(15);
      if ($urandom_range(99) < 75)
        send(fpc_pkg::CMD_CLASSIFY, clock_ms, proto, pool_port[sel], dp, pool_addr[sel], len);
      else
        send(fpc_pkg::CMD_CLASSIFY, clock_ms, proto, 16'($urandom), dp, $urandom, len);
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;  in_valid = 1'b0;  out_ready = 1'b0;  cfg_valid = 1'b0;
    in_cmd = fpc_pkg::CMD_CLASSIFY;  in_now_ms = '0;  in_protocol = '0;
    in_source_port = '0;  in_dest_port = '0;  in_source_address = '0;  in_data_length = '0;
    cfg_index = fpc_pkg::REG_PORT_COUNT;  cfg_data = '0;
    in_taken = 1'b0;  cfg_taken = 1'b0;  idle_on = 1'b1;
    pkts_queued = 0;  pkts_taken = 0;  mismatches = 0;
    port_cnt_q = 4'd2;  ports_lo_q = 64'd3473430;  ports_hi_q = '0;
    idle_ms_q = 32'd30000;  bulk_q = 32'd2000000;  rate_q = 20'd5120;
    for (int k = 0; k < fpc_pkg::FLOW_ENTRIES; k++) begin
      flow_live[k] = 1'b0;  flow_sport[k] = '0;  flow_addr[k] = '0;
      flow_first_ms[k] = '0;  flow_seen_ms[k] = '0;  flow_count[k] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset config (ports 22 and 53)
    send(fpc_pkg::CMD_CLASSIFY, 32'hFFFF_FFFF, fpc_pkg::PROTO_ICMP, 16'hFFFF, 16'hFFFF,
         32'hFFFF_FFFF, 16'hFFFF);
    send(fpc_pkg::CMD_CLASSIFY, 32'd0, 8'd0, 16'd22, 16'd0, 32'd0, 16'd0);
    send(fpc_pkg::CMD_CLASSIFY, 32'd0, 8'hFF, 16'd0, 16'd53, 32'd1, 16'd1);
    send(fpc_pkg::CMD_CLASSIFY, 32'd10, fpc_pkg::PROTO_TCP, 16'd22, 16'd9, 32'd5, 16'd100);
    send(fpc_pkg::CMD_CLASSIFY, 32'd10, fpc_pkg::PROTO_UDP, 16'd9, 16'd53, 32'd5, 16'd100);
    send(fpc_pkg::CMD_CLASSIFY, 32'd1000, fpc_pkg::PROTO_TCP, 16'd0, 16'd0, 32'd0, 16'd0);
    send(fpc_pkg::CMD_CLASSIFY, 32'd1500, fpc_pkg::PROTO_TCP, 16'd0, 16'd0, 32'd0, 16'hFFFF);
    send(fpc_pkg::CMD_CLASSIFY, 32'd1600, fpc_pkg::PROTO_UDP, 16'hFFFF, 16'hFFFF,
         32'hFFFF_FFFF, 16'hFFFF);
    // idle exactly at the limit keeps the entry, one more ms frees it
    send(fpc_pkg::CMD_TICK, 32'd31500, 8'd0, 16'd0, 16'd0, 32'd0, 16'd0);
    send(fpc_pkg::CMD_TICK, 32'd31601, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send(fpc_pkg::CMD_CLASSIFY, 32'd31700, fpc_pkg::PROTO_TCP, 16'd0, 16'd0, 32'd0, 16'd7);
    send(fpc_pkg::CMD_CLASSIFY, 32'd31700, fpc_pkg::PROTO_UDP, 16'hFFFF, 16'd1,
         32'hFFFF_FFFF, 16'd7);
    settle();

    // count above the slot limit, tiny thresholds: every hit with a nonzero count goes low
    write_reg(fpc_pkg::REG_PORT_COUNT, 64'hF);
    write_reg(fpc_pkg::REG_PORTS_LO, {$urandom, $urandom});
    write_reg(fpc_pkg::REG_PORTS_HI, {$urandom, $urandom});
    write_reg(fpc_pkg::REG_IDLE, 64'd5000);
    write_reg(fpc_pkg::REG_BULK, 64'd0);
    write_reg(fpc_pkg::REG_RATE, 64'd0);
    write_reg(3'd6, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(3'd7, 64'h0);
    new_pool();
    clock_ms = 32'd50_000;
    send(fpc_pkg::CMD_CLASSIFY, clock_ms, fpc_pkg::PROTO_TCP, pool_port[0], 16'd1,
         pool_addr[0], 16'd0);
    send(fpc_pkg::CMD_CLASSIFY, clock_ms, fpc_pkg::PROTO_TCP, pool_port[0], 16'd1,
         pool_addr[0], 16'd1);
    random_traffic(180);
    settle();

    // extremes: no high ports, nothing ever ages, nothing bulk; overfill the table
    write_reg(fpc_pkg::REG_PORT_COUNT, 64'd0);
    write_reg(fpc_pkg::REG_PORTS_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(fpc_pkg::REG_PORTS_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(fpc_pkg::REG_IDLE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(fpc_pkg::REG_BULK, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(fpc_pkg::REG_RATE, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int k = 0; k < fpc_pkg::FLOW_ENTRIES + 12; k++)
      send(fpc_pkg::CMD_CLASSIFY, clock_ms + 32'(k), fpc_pkg::PROTO_UDP, 16'(k), 16'hFFFF,
           32'hA000_0000 + 32'(k), 16'(k));
    send(fpc_pkg::CMD_TICK, clock_ms + 32'd200, 8'd0, 16'd0, 16'd0, 32'd0, 16'd0);
    settle();
    // zero idle limit sweeps everything older than now
    write_reg(fpc_pkg::REG_IDLE, 64'd0);
    send(fpc_pkg::CMD_TICK, clock_ms + 32'd300, 8'd0, 16'd0, 16'd0, 32'd0, 16'd0);
    send(fpc_pkg::CMD_CLASSIFY, clock_ms + 32'd300, fpc_pkg::PROTO_TCP, 16'd3, 16'd0,
         32'hA000_0003, 16'd1);
    send(fpc_pkg::CMD_TICK, clock_ms + 32'd300, 8'd0, 16'd0, 16'd0, 32'd0, 16'd0);
    settle();

    // full port list, real thresholds, time running across the 32-bit wrap
    write_reg(fpc_pkg::REG_PORT_COUNT, 64'd8);
    write_reg(fpc_pkg::REG_PORTS_LO, {$urandom, $urandom});
    write_reg(fpc_pkg::REG_PORTS_HI, {$urandom, $urandom});
    write_reg(fpc_pkg::REG_IDLE, 64'd2000);
    write_reg(fpc_pkg::REG_BULK, 64'd50000);
    write_reg(fpc_pkg::REG_RATE, 64'd20000);
    new_pool();
    clock_ms = 32'hFFFF_FFFF - 32'd40_000;
    idle_on = 1'b0;               // back-to-back stretch
    random_traffic(120);
    settle();
    idle_on = 1'b1;
    write_reg(fpc_pkg::REG_PORT_COUNT, 64'd5);
    write_reg(fpc_pkg::REG_BULK, 64'd200000);
    write_reg(fpc_pkg::REG_RATE, 64'($urandom_range(1000, 200000)));
    write_reg(fpc_pkg::REG_IDLE, 64'd30000);
    random_traffic(180);
    settle();

    if (mismatches == 0) $display("tb_flow_priority_classifier_core OK");
    else $display("tb_flow_priority_classifier_core NOT OK");
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("tb_flow_priority_classifier_core NOT OK");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/fpc_pkg.sv
rtl/core/fpc_front.sv
rtl/core/fpc_back.sv
rtl/core/flow_priority_classifier_core.sv
tb/tb_flow_priority_classifier_core.sv
